/* rtl/core/serial_frame_autodetect_unit_defines.svh */
// Assertion macros for the serial frame autodetect checker.
`ifndef SERIAL_FRAME_AUTODETECT_UNIT_DEFINES_SVH
`define SERIAL_FRAME_AUTODETECT_UNIT_DEFINES_SVH

// Check that a condition implies an expression in the same cycle.
`define SFAD_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies an expression in the following cycle.
`define SFAD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/core/sfad_pkg.sv */
// Package: item types, frame codes and constants for the serial frame autodetect unit.
`timescale 1ns / 1ps

package sfad_pkg;

    // Default frame length limit
    localparam int FRAME_LIMIT_DEFAULT = 128;

    // Frame kind codes
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_TEXT     = 3'd1;
    localparam logic [2:0] KIND_SENSOR   = 3'd2;
    localparam logic [2:0] KIND_COMMAND  = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW = 3'd4;

    // Byte values
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;
    localparam logic [7:0] CMD_LED    = 8'h01;

    // Frame geometry
    localparam int         SENSOR_LEN   = 5;
    localparam int         CMD_MIN_LEN  = 3;
    localparam logic [8:0] CMD_OVERHEAD = 9'd3;
    localparam int         HEAD_DEPTH   = 4;

    // Input item
    typedef struct packed {
        logic [7:0] rx_byte;
    } sfad_byte_t;

    // Result item
    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [6:0]  frame_bytes;
        logic [15:0] temperature_raw;
        logic [15:0] humidity_raw;
        logic [7:0]  command_id;
        logic [7:0]  payload_length;
        logic        led_on;
    } sfad_result_t;

    // First bytes of the current frame
    typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

    // Running frame state apart from the byte count
    typedef struct packed {
        logic [7:0] sum_before;
        logic       all_printable;
        logic       led_level;
    } frame_state_t;

endpackage

/* rtl/core/sfad_stream_if.sv */
// Valid/ready stream interface carrying one item per handshake.
`timescale 1ns / 1ps

interface sfad_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/sfad_decode.sv */
// Single-pass frame classifier: result item and next frame state for one byte.
`timescale 1ns / 1ps

module sfad_decode #(
    parameter int FRAME_LIMIT = sfad_pkg::FRAME_LIMIT_DEFAULT,
    localparam int CW = $clog2(FRAME_LIMIT)
) (
    input  logic [7:0]             rx_byte,
    input  logic [CW-1:0]          count,
    input  sfad_pkg::frame_state_t state,
    input  sfad_pkg::head_t        head,
    output logic [CW-1:0]          count_next,
    output sfad_pkg::frame_state_t state_next,
    output sfad_pkg::head_t        head_next,
    output sfad_pkg::sfad_result_t result
);

    logic [CW-1:0] n;
    logic [2:0]    kind;
    logic          is_text;
    logic          is_sensor;
    logic          is_command;
    logic [7:0]    third;

    // Classify the byte against the three frame types, text first
    always_comb
    begin
        n          = count + CW'(1);
        is_text    = (rx_byte inside {sfad_pkg::BYTE_LF, sfad_pkg::BYTE_CR})
                     && state.all_printable;
        is_sensor  = (n == CW'(sfad_pkg::SENSOR_LEN)) && (state.sum_before == rx_byte);
        is_command = (n >= CW'(sfad_pkg::CMD_MIN_LEN))
                     && (9'(n) == (9'(head[1]) + sfad_pkg::CMD_OVERHEAD))
                     && (state.sum_before == rx_byte);
        // A short command frame has its checksum as the third byte
        third      = (n == CW'(sfad_pkg::CMD_MIN_LEN)) ? rx_byte : head[2];

        if (is_text)
        begin
            kind = sfad_pkg::KIND_TEXT;
        end
        else if (is_sensor)
        begin
            kind = sfad_pkg::KIND_SENSOR;
        end
        else if (is_command)
        begin
            kind = sfad_pkg::KIND_COMMAND;
        end
        else
        begin
            kind = sfad_pkg::KIND_NONE;
        end
    end

    // Build the result and advance the frame state
    always_comb
    begin
        result     = '0;
        count_next = n;
        state_next = state;
        head_next  = head;

        if (kind == sfad_pkg::KIND_SENSOR)
        begin
            result.temperature_raw = {head[0], head[1]};
            result.humidity_raw    = {head[2], head[3]};
        end
        else if (kind == sfad_pkg::KIND_COMMAND)
        begin
            result.command_id     = head[0];
            result.payload_length = head[1];
            if (head[0] == sfad_pkg::CMD_LED)
            begin
                state_next.led_level = (third != 8'd0);
            end
        end

        if (kind != sfad_pkg::KIND_NONE)
        begin
            // Frame complete: report and restart
            result.frame_kind        = kind;
            result.frame_bytes       = 7'(n);
            count_next               = '0;
            state_next.sum_before    = '0;
            state_next.all_printable = 1'b1;
        end
        else
        begin
            // Accumulate the byte into the open frame
            if (count < CW'(sfad_pkg::HEAD_DEPTH))
            begin
                head_next[count[1:0]] = rx_byte;
            end
            state_next.sum_before = state.sum_before + rx_byte;
            if (!(rx_byte inside {[sfad_pkg::PRINT_LOW:sfad_pkg::PRINT_HIGH]}))
            begin
                state_next.all_printable = 1'b0;
            end
            // Drop the frame once its byte count reaches FRAME_LIMIT - 1
            if (n >= CW'(FRAME_LIMIT - 1))
            begin
                result.frame_kind        = sfad_pkg::KIND_OVERFLOW;
                result.frame_bytes       = 7'(n);
                count_next               = '0;
                state_next.sum_before    = '0;
                state_next.all_printable = 1'b1;
            end
        end

        result.led_on = state_next.led_level;
    end

endmodule

/* rtl/core/serial_frame_autodetect_unit.sv */
// Top level of the serial frame autodetect unit: input register, frame state, result register.
`timescale 1ns / 1ps

// Takes one received byte per item and returns one result item per byte: the
// kind of frame that the byte completes (none, text, sensor, command or an
// overflow drop), the frame length and the decoded raw fields, plus the LED
// level. A byte passes through an input register, one pass of decode logic
// and the result register, and a new byte can be taken every cycle while the
// result side keeps up. The input register lets a byte be taken while a
// finished result still waits. No clearing pass runs after reset; the unit
// takes bytes at once.
module serial_frame_autodetect_unit #(
    parameter int FRAME_LIMIT = sfad_pkg::FRAME_LIMIT_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    sfad_stream_if.sink   byte_ch,
    sfad_stream_if.source frame_ch
);

    localparam int CW = $clog2(FRAME_LIMIT);

    logic                   byte_valid_reg;
    logic [7:0]             byte_reg;
    logic                   out_valid_reg;
    sfad_pkg::sfad_result_t result_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    sfad_pkg::frame_state_t state_reg;
    sfad_pkg::frame_state_t state_next;
    sfad_pkg::head_t        head_reg;
    sfad_pkg::head_t        head_next;
    sfad_pkg::sfad_result_t result_next;
    logic                   advance;

    // Move the held byte into the result register when that slot frees up
    assign advance       = byte_valid_reg && (!out_valid_reg || frame_ch.ready);
    assign byte_ch.ready = !byte_valid_reg || advance;

    assign frame_ch.valid   = out_valid_reg;
    assign frame_ch.payload = result_reg;

    sfad_decode #(
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_decode (
        .rx_byte    (byte_reg),
        .count      (count_reg),
        .state      (state_reg),
        .head       (head_reg),
        .count_next (count_next),
        .state_next (state_next),
        .head_next  (head_next),
        .result     (result_next)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            byte_valid_reg <= byte_ch.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            byte_reg <= byte_ch.payload.rx_byte;
        end
    end

    // Frame state, updated as each item is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg                <= '0;
            state_reg.sum_before     <= '0;
            state_reg.all_printable  <= 1'b1;
            state_reg.led_level      <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            state_reg <= state_next;
        end
    end

    // Head bytes hold no reset: each is written before it is read in a frame
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_reg <= head_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* rtl/core/sfad_checker.sv */
// Port-level checker for the serial frame autodetect unit, bound to the top level.
`timescale 1ns / 1ps
`include "serial_frame_autodetect_unit_defines.svh"

module sfad_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   valid,
    input logic                   ready,
    input sfad_pkg::sfad_result_t result
);

    // No frame: length and every decoded field read zero; the LED level is not checked
    `SFAD_ASSERT_NOW(a_none_clear, valid && (result.frame_kind == sfad_pkg::KIND_NONE), (result.frame_bytes == 7'd0) && (result.temperature_raw == 16'd0) && (result.humidity_raw == 16'd0) && (result.command_id == 8'd0) && (result.payload_length == 8'd0), "frame kind none with nonzero fields")

    // Sensor frame: five bytes, no command fields
    `SFAD_ASSERT_NOW(a_sensor_shape, valid && (result.frame_kind == sfad_pkg::KIND_SENSOR), (result.frame_bytes == 7'd5) && (result.command_id == 8'd0) && (result.payload_length == 8'd0), "sensor item malformed")

    // Command frame: length follows the payload length, no sensor fields
    `SFAD_ASSERT_NOW(a_command_shape, valid && (result.frame_kind == sfad_pkg::KIND_COMMAND), (7'(result.payload_length + 8'd3) == result.frame_bytes) && (result.temperature_raw == 16'd0) && (result.humidity_raw == 16'd0), "command item malformed")

    // Stalled result holds
    `SFAD_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(result), "result changed while stalled")

endmodule

bind serial_frame_autodetect_unit sfad_checker u_sfad_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (frame_ch.valid),
    .ready  (frame_ch.ready),
    .result (frame_ch.payload)
);
